// File: sv/tbcc_pkg.sv
// shared types and codes for the two-button click classifier
`default_nettype none

package tbcc_pkg;

  // operation codes of an input item
  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // report codes of a result item
  localparam logic [1:0] REPORT_NONE   = 2'd0;
  localparam logic [1:0] REPORT_CLICKS = 2'd1;
  localparam logic [1:0] REPORT_HOLD   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SHORT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_SPACE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_HOLD_LIMIT  = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 26;

  // click counter slots
  localparam int NUM_BUTTONS = 2;
  localparam int NUM_COUNTS  = 4;

  typedef struct packed {
    logic        operation;
    logic        power_pin;
    logic        aux_pin;
    logic        irq_pin;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] report;
    logic [7:0] power_short_count;
    logic [7:0] power_long_count;
    logic [7:0] aux_short_count;
    logic [7:0] aux_long_count;
    logic       irq_raised;
  } out_item_t;

  typedef struct packed {
    logic [15:0] short_limit_ms;
    logic [15:0] space_limit_ms;
    logic [25:0] hold_limit_ms;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/two_button_click_classifier.sv
// top level: input register, classifier core, result register, config port
`default_nettype none

// Classifies presses of an active-low power button and aux button into short
// and long clicks, reports a burst of clicks after a quiet time, reports a
// power-button hold, and flags rising edges of an IRQ pin. Each input item
// gives exactly one result item. Items pass an input register and a result
// register, and one item per cycle is taken sustained while the receiver
// does not stall; the only loop is the click state updated once per item in
// the core. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while no item is in flight; the block does not enforce it.
// A short limit at or below twice DEBOUNCE_TIME_MS is raised to that value.
module two_button_click_classifier import tbcc_pkg::*; #(
  parameter int unsigned DEBOUNCE_TIME_MS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  out_item_t res;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      s2_free;
  logic      adv;
  logic      in_fire;

  tbcc_cfg #(
    .DEBOUNCE_TIME_MS(DEBOUNCE_TIME_MS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  tbcc_core #(
    .DEBOUNCE_TIME_MS(DEBOUNCE_TIME_MS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (adv),
    .item (s1_item_r),
    .cfg  (cfg),
    .res  (res)
  );

  // handshake: the input register moves on whenever the result slot frees
  assign s2_free  = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_fire  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a stall is raised only with an item waiting in the input register
  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with an empty input register");

  // a blocked item waits in place for the result slot
  a_s1_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("waiting item lost from the input register");

  // a stalled result item holds its payload
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("result item changed while stalled");

endmodule

`default_nettype wire

// File: sv/tbcc_cfg.sv
// configuration registers with the short-limit floor applied on write
`default_nettype none

module tbcc_cfg import tbcc_pkg::*; #(
  parameter int unsigned DEBOUNCE_TIME_MS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  localparam logic [15:0] SHORT_FLOOR = 16'(2 * DEBOUNCE_TIME_MS);

  cfg_t        cfg_r;
  logic [15:0] short_wr;

  // short limit never below twice the debounce time
  assign short_wr = (cfg_data[15:0] > SHORT_FLOOR) ? cfg_data[15:0] : SHORT_FLOOR;

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_LIMIT: cfg_r.short_limit_ms <= short_wr;
        CFG_SPACE_LIMIT: cfg_r.space_limit_ms <= cfg_data[15:0];
        CFG_HOLD_LIMIT:  cfg_r.hold_limit_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: sv/tbcc_core.sv
// press timing state and single-pass click and hold classification
`default_nettype none

module tbcc_core import tbcc_pkg::*; #(
  parameter int unsigned DEBOUNCE_TIME_MS = 20
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     res
);

  localparam logic [31:0] DEBOUNCE_W = 32'(DEBOUNCE_TIME_MS);

  logic [2:0]  prev_pins_r, prev_pins_nxt;
  logic [31:0] start_r   [NUM_BUTTONS];
  logic [31:0] start_nxt [NUM_BUTTONS];
  logic [7:0]  cnt_r     [NUM_COUNTS];
  logic [7:0]  cnt_nxt   [NUM_COUNTS];
  logic [31:0] last_rel_r, last_rel_nxt;

  logic [2:0]  pins;
  logic [2:0]  chg;
  logic [31:0] press_t [NUM_BUTTONS];
  logic [31:0] space_t;
  logic [31:0] hold_t;
  logic        clicks_due;
  logic        hold_due;

  assign pins = {item.irq_pin, item.aux_pin, item.power_pin};
  assign chg  = pins ^ prev_pins_r;

  // elapsed times against the stored marks
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      press_t[i] = item.now_ms - start_r[i];
    end
  end
  assign space_t    = item.now_ms - last_rel_r;
  assign hold_t     = item.now_ms - start_r[0];
  assign clicks_due = (last_rel_r != '0) && (space_t > {16'd0, cfg.space_limit_ms});
  assign hold_due   = (start_r[0] != '0) && (hold_t > {6'd0, cfg.hold_limit_ms});

  // next state and result for one item
  always_comb begin
    prev_pins_nxt = prev_pins_r;
    last_rel_nxt  = last_rel_r;
    for (int i = 0; i < NUM_BUTTONS; i++) start_nxt[i] = start_r[i];
    for (int k = 0; k < NUM_COUNTS; k++) cnt_nxt[k] = cnt_r[k];
    res = '0;

    if (item.operation == OP_PIN) begin
      res.irq_raised = chg[2] & pins[2];
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (chg[i]) begin
          if (!pins[i]) begin
            start_nxt[i] = item.now_ms;
          end else begin
            // release: classify a press that outlasted the debounce time
            if (start_r[i] != '0 && press_t[i] > DEBOUNCE_W) begin
              if (press_t[i] <= {16'd0, cfg.short_limit_ms})
                cnt_nxt[2*i] = cnt_r[2*i] + 8'd1;
              else
                cnt_nxt[2*i+1] = cnt_r[2*i+1] + 8'd1;
              last_rel_nxt = item.now_ms;
            end
            start_nxt[i] = '0;
          end
        end
      end
      prev_pins_nxt = pins;
    end else if (clicks_due) begin
      // hand over the counts and start a fresh burst
      res.report            = REPORT_CLICKS;
      res.power_short_count = cnt_r[0];
      res.power_long_count  = cnt_r[1];
      res.aux_short_count   = cnt_r[2];
      res.aux_long_count    = cnt_r[3];
      for (int k = 0; k < NUM_COUNTS; k++) cnt_nxt[k] = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) start_nxt[i] = '0;
      last_rel_nxt  = '0;
      prev_pins_nxt = pins;
    end else if (hold_due) begin
      // hold only while the power button is still down
      if (!pins[0]) res.report = REPORT_HOLD;
      else          start_nxt[0] = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r <= 3'b111;
      last_rel_r  <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) start_r[i] <= '0;
      for (int k = 0; k < NUM_COUNTS; k++) cnt_r[k] <= '0;
    end else if (fire) begin
      prev_pins_r <= prev_pins_nxt;
      last_rel_r  <= last_rel_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) start_r[i] <= start_nxt[i];
      for (int k = 0; k < NUM_COUNTS; k++) cnt_r[k] <= cnt_nxt[k];
    end
  end

  // a click report leaves an empty burst behind
  a_clicks_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.report == REPORT_CLICKS) |=>
      (cnt_r[0] == '0 && cnt_r[1] == '0 && cnt_r[2] == '0 && cnt_r[3] == '0 &&
       last_rel_r == '0 && start_r[0] == '0 && start_r[1] == '0))
    else $error("click report did not clear the burst state");

  // irq edges come only from pin samples
  a_irq_pin_only: assert property (@(posedge clk) disable iff (!rst_n)
    res.irq_raised |-> (item.operation == OP_PIN && res.report == REPORT_NONE))
    else $error("irq flag on a poll item");

  // counts travel only with a click report
  a_counts_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (res.report != REPORT_CLICKS) |->
      (res.power_short_count == '0 && res.power_long_count == '0 &&
       res.aux_short_count == '0 && res.aux_long_count == '0))
    else $error("counts present without a click report");

endmodule

`default_nettype wire

// File: sim/click_tracker_pkg.sv
// expected-report tracker for the two-button click classifier bench
package click_tracker_pkg;
  import tbcc_pkg::*;

  localparam int unsigned BOUNCE_WINDOW_MS = 20;
  localparam int MAX_MISMATCH_LINES = 40;

  class click_tracker;
    // limits as the block holds them
    bit [31:0] short_limit;
    bit [31:0] space_limit;
    bit [31:0] hold_limit;

    // click state: pins bit0 power, bit1 aux, bit2 irq
    bit [2:0]  last_pins;
    bit [31:0] press_start [NUM_BUTTONS];
    bit [7:0]  clicks [NUM_COUNTS];
    bit [31:0] release_time;

    out_item_t expected_reports [$];
    int errors;

    function new();
      short_limit = 0;
      space_limit = 0;
      hold_limit = 0;
      errors = 0;
      forget_clicks(3'b111);
    endfunction

    function void forget_clicks(bit [2:0] pins);
      foreach (clicks[k]) clicks[k] = 8'd0;
      press_start[0] = 32'd0;
      press_start[1] = 32'd0;
      release_time = 32'd0;
      last_pins = pins;
    endfunction

    // register write, short limit never below twice the debounce time
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      bit [31:0] v;
      v = {16'd0, data[15:0]};
      case (idx)
        CFG_SHORT_LIMIT: short_limit = (v > 2 * BOUNCE_WINDOW_MS) ? v : 2 * BOUNCE_WINDOW_MS;
        CFG_SPACE_LIMIT: space_limit = v;
        CFG_HOLD_LIMIT: hold_limit = {6'd0, data};
        default: ;
      endcase
    endfunction

    // work out the report an accepted item causes
    function void note_item(in_item_t it);
      out_item_t r;
      bit [2:0]  pins;
      bit [2:0]  chg;
      bit [31:0] held;
      r = '0;
      pins = {it.irq_pin, it.aux_pin, it.power_pin};
      if (it.operation == OP_PIN) begin
        chg = pins ^ last_pins;
        r.irq_raised = chg[2] & pins[2];
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (chg[b]) begin
            if (!pins[b]) begin
              press_start[b] = it.now_ms;
            end else begin
              // a start time of zero means the press is not tracked
              if (press_start[b] != 32'd0) begin
                held = it.now_ms - press_start[b];
                if (held > BOUNCE_WINDOW_MS) begin
                  if (held <= short_limit) clicks[2 * b] = clicks[2 * b] + 8'd1;
                  else clicks[2 * b + 1] = clicks[2 * b + 1] + 8'd1;
                  release_time = it.now_ms;
                end
              end
              press_start[b] = 32'd0;
            end
          end
        end
        last_pins = pins;
      end else begin
        held = it.now_ms - release_time;
        if (release_time != 32'd0 && held > space_limit) begin
          // burst done: hand over counts and re-sample the pins
          r.report = REPORT_CLICKS;
          r.power_short_count = clicks[0];
          r.power_long_count = clicks[1];
          r.aux_short_count = clicks[2];
          r.aux_long_count = clicks[3];
          forget_clicks(pins);
        end else begin
          held = it.now_ms - press_start[0];
          if (press_start[0] != 32'd0 && held > hold_limit) begin
            if (!pins[0]) r.report = REPORT_HOLD;
            else press_start[0] = 32'd0;
          end
        end
      end
      expected_reports.push_back(r);
    endfunction

    function void match_field(string name, logic [7:0] want, logic [7:0] got,
                              longint unsigned stamp);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_MISMATCH_LINES)
          $display("%0t: %s expected %0d got %0d", stamp, name, want, got);
      end
    endfunction

    // compare one result with the oldest expected report
    function void check_report(out_item_t got, longint unsigned stamp);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_MISMATCH_LINES)
          $display("%0t: result %h with no item pending, expected none", stamp, got);
        return;
      end
      want = expected_reports.pop_front();
      match_field("report", {6'd0, want.report}, {6'd0, got.report}, stamp);
      match_field("power_short_count", want.power_short_count, got.power_short_count, stamp);
      match_field("power_long_count", want.power_long_count, got.power_long_count, stamp);
      match_field("aux_short_count", want.aux_short_count, got.aux_short_count, stamp);
      match_field("aux_long_count", want.aux_long_count, got.aux_long_count, stamp);
      match_field("irq_raised", {7'd0, want.irq_raised}, {7'd0, got.irq_raised}, stamp);
    endfunction

    function int pending_count();
      return expected_reports.size();
    endfunction
  endclass

endpackage

// File: sim/tb_two_button_click_classifier.sv
// testbench top: button and poll stimulus, handshake drivers, report checking
module tb_two_button_click_classifier;
  import tbcc_pkg::*;
  import click_tracker_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int END_WAIT = 10;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  click_tracker tracker;

  // items waiting to be offered, and handshake bookkeeping
  in_item_t stim_q [$];
  int queued_total = 0;
  int accepted_total = 0;
  int tx_gap = 0;
  int rx_stall_len;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  // button model on the stimulus side
  bit [31:0] clock_ms = 32'd0;
  bit [31:0] press_ms [2];
  bit [31:0] release_ms = 32'd0;
  bit pw_level = 1'b1;
  bit ax_level = 1'b1;
  bit irq_level = 1'b1;

  two_button_click_classifier #(
    .DEBOUNCE_TIME_MS(BOUNCE_WINDOW_MS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sender: offer queued items, hold the payload while stalled
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tracker.note_item(in_item);
      accepted_total++;
    end
    if (!(in_valid && in_stall)) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (stim_q.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= stim_q.pop_front();
        tx_gap = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm) begin
        rx_stall_len = pick_gap();
        if (rx_stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (rx_stall_len) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_report(out_item, $time);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic op, logic [2:0] pins, logic [31:0] t);
    in_item_t it;
    it.operation = op;
    it.power_pin = pins[0];
    it.aux_pin = pins[1];
    it.irq_pin = pins[2];
    it.now_ms = t;
    return it;
  endfunction

  function automatic void push_item(in_item_t it);
    stim_q.push_back(it);
    queued_total++;
  endfunction

  function automatic void push_pins(logic op);
    push_item(mk_item(op, {irq_level, ax_level, pw_level}, clock_ms));
  endfunction

  // random data above the 16-bit field, to check masking of the write
  function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned v);
    logic [31:0] r;
    r = $urandom();
    r[15:0] = v[15:0];
    return r[CFG_DATA_W-1:0];
  endfunction

  task automatic wait_accepted();
    while (accepted_total != queued_total) @(posedge clk);
  endtask

  task automatic wait_results();
    wait_accepted();
    while (tracker.pending_count() != 0) @(posedge clk);
  endtask

  // write all three limits and poke the unused index, block idle
  task automatic load_limits(input logic [CFG_DATA_W-1:0] short_data,
                             input logic [CFG_DATA_W-1:0] space_data,
                             input logic [CFG_DATA_W-1:0] hold_data);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    logic [31:0] junk;
    junk = $urandom();
    idx = '{CFG_SHORT_LIMIT, CFG_SPACE_LIMIT, CFG_HOLD_LIMIT, CFG_UNUSED};
    val = '{short_data, space_data, hold_data, junk[CFG_DATA_W-1:0]};
    for (int k = 0; k < 4; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      tracker.write_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // press length: bounce, near the short limit, or anything
  function automatic bit [31:0] press_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(BOUNCE_WINDOW_MS - 3, BOUNCE_WINDOW_MS + 3);
    else if (r < 50) return tracker.short_limit - 2 + $urandom_range(0, 4);
    else if (r < 85) return $urandom_range(0, tracker.short_limit * 2 + 60);
    else if (r < 95) return $urandom_range(0, 200000);
    return $urandom();
  endfunction

  // time between presses, sometimes landing on zero
  function automatic bit [31:0] idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 400);
    else if (r < 92) return tracker.space_limit - 2 + $urandom_range(0, 4);
    else if (r < 97) return $urandom();
    return 32'd0 - clock_ms;
  endfunction

  // poll time near the quiet limit, near the hold limit, or random
  function automatic bit [31:0] poll_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return release_ms + tracker.space_limit - 2 + $urandom_range(0, 4);
    else if (r < 55) return press_ms[0] + tracker.hold_limit - 2 + $urandom_range(0, 4);
    else if (r < 88) return clock_ms + $urandom_range(0, 3000);
    return clock_ms + $urandom();
  endfunction

  task automatic toggle_buttons(input bit do_power, input bit do_aux);
    bit releasing;
    releasing = do_power ? !pw_level : !ax_level;
    if (releasing) clock_ms = (do_power ? press_ms[0] : press_ms[1]) + press_length();
    else clock_ms = clock_ms + idle_length();
    if (do_power) begin
      pw_level = !pw_level;
      if (!pw_level) press_ms[0] = clock_ms;
    end
    if (do_aux) begin
      ax_level = !ax_level;
      if (!ax_level) press_ms[1] = clock_ms;
    end
    if (releasing) release_ms = clock_ms;
    push_pins(OP_PIN);
  endtask

  // mostly press/release sequences and polls, some noise
  task automatic run_activity(input int count);
    int r;
    int b;
    logic [31:0] rnd;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        b = $urandom_range(0, 1);
        toggle_buttons(b == 0, b == 1);
      end else if (r < 53) begin
        if (pw_level == ax_level) toggle_buttons(1'b1, 1'b1);
        else toggle_buttons(!pw_level, !ax_level);
      end else if (r < 60) begin
        irq_level = !irq_level;
        clock_ms += $urandom_range(0, 50);
        push_pins(OP_PIN);
      end else if (r < 88) begin
        clock_ms = poll_time();
        push_pins(OP_POLL);
      end else if (r < 94) begin
        rnd = $urandom();
        pw_level = rnd[0];
        ax_level = rnd[1];
        irq_level = rnd[2];
        clock_ms = $urandom();
        press_ms[0] = clock_ms;
        press_ms[1] = clock_ms;
        push_pins(OP_PIN);
      end else begin
        rnd = $urandom();
        push_item(mk_item(OP_POLL, rnd[2:0], $urandom()));
      end
    end
  endtask

  // many short clicks on both buttons with no poll, so the counts wrap
  task automatic click_flood(input int rounds);
    for (int k = 0; k < rounds; k++) begin
      clock_ms += $urandom_range(30, 200);
      pw_level = 1'b0;
      ax_level = 1'b0;
      push_pins(OP_PIN);
      clock_ms += $urandom_range(BOUNCE_WINDOW_MS + 1, tracker.short_limit);
      pw_level = 1'b1;
      ax_level = 1'b1;
      push_pins(OP_PIN);
    end
    release_ms = clock_ms;
    clock_ms += tracker.space_limit + 1;
    push_pins(OP_POLL);
  endtask

  initial begin
    tracker = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed items with the reset limits
    push_item(mk_item(OP_PIN, 3'b111, 32'd0));
    push_item(mk_item(OP_PIN, 3'b110, 32'd0));          // press at time zero
    push_item(mk_item(OP_PIN, 3'b111, 32'd100));        // its release is not counted
    push_item(mk_item(OP_POLL, 3'b111, 32'd200));
    push_item(mk_item(OP_PIN, 3'b001, 32'd1000));
    push_item(mk_item(OP_PIN, 3'b111, 32'd1010));       // bounce, irq rises
    push_item(mk_item(OP_PIN, 3'b101, 32'd2000));
    push_item(mk_item(OP_PIN, 3'b111, 32'd2021));       // just past debounce
    push_item(mk_item(OP_POLL, 3'b111, 32'd2021));
    push_item(mk_item(OP_POLL, 3'b111, 32'd2022));      // clicks handed over
    push_item(mk_item(OP_PIN, 3'b110, 32'hFFFF_FFE0));
    push_item(mk_item(OP_PIN, 3'b111, 32'd0));          // release at time zero
    push_item(mk_item(OP_POLL, 3'b111, 32'd5));
    push_item(mk_item(OP_PIN, 3'b110, 32'd10));
    push_item(mk_item(OP_POLL, 3'b110, 32'd10));
    push_item(mk_item(OP_POLL, 3'b110, 32'd11));        // power hold
    push_item(mk_item(OP_POLL, 3'b111, 32'd12));        // hold, button already up
    push_item(mk_item(OP_PIN, 3'b111, 32'd50));
    push_item(mk_item(OP_PIN, 3'b100, 32'd100));
    push_item(mk_item(OP_PIN, 3'b101, 32'd150));
    push_item(mk_item(OP_POLL, 3'b011, 32'd151));       // hand-over re-samples pins
    push_item(mk_item(OP_PIN, 3'b111, 32'd160));
    push_item(mk_item(OP_PIN, 3'b111, 32'hFFFF_FFFF));
    push_item(mk_item(OP_POLL, 3'b000, 32'hFFFF_FFFF));
    wait_results();
    clock_ms = 32'd1000;

    // short limit written below the floor
    load_limits(with_noise(5), with_noise(30), 26'd100);
    run_activity(35);
    wait_results();

    // counter wrap
    click_flood(260);
    wait_results();

    // receiver holds off while items keep coming, then the sender drains
    calm = 1'b1;
    hold_off_req = 1'b1;
    run_activity(30);
    wait_accepted();
    calm = 1'b0;
    wait_results();

    // top of the short and space ranges
    load_limits(with_noise(16'hFFFF), with_noise(16'hFFFF), 26'd65535000);
    run_activity(35);
    wait_results();

    // bottom of every range
    load_limits(with_noise(0), with_noise(0), 26'd0);
    run_activity(35);
    wait_results();

    // random limits, widest hold, no idling
    calm = 1'b1;
    load_limits(with_noise($urandom_range(0, 2000)), with_noise($urandom_range(0, 2000)),
                26'h3FF_FFFF);
    run_activity(35);
    wait_results();
    calm = 1'b0;

    // mid-range limits with a hold-off in the middle
    load_limits(with_noise(300), with_noise(500), 26'd2000);
    run_activity(20);
    wait_accepted();
    hold_off_req = 1'b1;
    run_activity(20);
    wait_results();

    repeat (END_WAIT) @(posedge clk);
    if (tracker.pending_count() != 0)
      $display("%0t: %0d expected results never arrived", $time, tracker.pending_count());
    if (tracker.errors == 0 && tracker.pending_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: two_button_click_classifier.f
sv/tbcc_pkg.sv
sv/tbcc_cfg.sv
sv/tbcc_core.sv
sv/two_button_click_classifier.sv
sim/click_tracker_pkg.sv
sim/tb_two_button_click_classifier.sv
